@@ hdl/ptf_pkg.sv @@
// Shared constants and types for the paged translation block with FIFO frame replacement.
package ptf_pkg;

   // Field widths of the request and response transactions
   localparam int PROC_W   = 1;
   localparam int VA_W     = 12;
   localparam int PAGE_W   = 4;
   localparam int OFFSET_W = 8;
   localparam int FRAME_W  = 3;
   localparam int PA_W     = FRAME_W + OFFSET_W;

   // Physical memory geometry
   localparam int FRAME_COUNT = 8;
   localparam int LOADED_W    = $clog2(FRAME_COUNT + 1);

   // Page table: one entry per (process, page)
   localparam int PT_IDX_W = PROC_W + PAGE_W;
   localparam int PT_DEPTH = 1 << PT_IDX_W;

   // Owner of a frame: the process and virtual page mapped to it
   typedef struct packed {
      logic [PROC_W-1:0] proc;
      logic [PAGE_W-1:0] page;
   } owner_type;

   // Control from the translation sequencer to the frame allocator
   typedef struct packed {
      logic      fetch;     // read the owner of the current victim frame
      logic      commit;    // a fault takes the chosen frame
      owner_type owner;     // new owner written on commit
   } alloc_ctl_type;

   // Allocator answer for the transaction at hand
   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               evict;
      owner_type          victim;
   } alloc_res_type;

   // Response payload
   typedef struct packed {
      logic                 hit;
      logic [PAGE_W-1:0]    page_number;
      logic [OFFSET_W-1:0]  page_offset;
      logic [FRAME_W-1:0]   frame_number;
      logic [PA_W-1:0]      physical_address;
      logic                 evicted;
      logic [PROC_W-1:0]    evicted_process;
      logic [PAGE_W-1:0]    evicted_page;
   } rsp_type;

endpackage

@@ hdl/ptf_req_if.sv @@
// Request channel: process id and virtual address with valid/ready handshake.
interface ptf_req_if import ptf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PROC_W-1:0]   process_id;
   logic [VA_W-1:0]     virtual_address;

   modport source (output valid, output process_id, output virtual_address, input ready);
   modport sink   (input valid, input process_id, input virtual_address, output ready);
endinterface

@@ hdl/ptf_rsp_if.sv @@
// Response channel: translation result with valid/ready handshake.
interface ptf_rsp_if import ptf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic [PAGE_W-1:0]   page_number;
   logic [OFFSET_W-1:0] page_offset;
   logic [FRAME_W-1:0]  frame_number;
   logic [PA_W-1:0]     physical_address;
   logic                evicted;
   logic [PROC_W-1:0]   evicted_process;
   logic [PAGE_W-1:0]   evicted_page;

   modport source (
      output valid, input ready,
      output hit, output page_number, output page_offset, output frame_number,
      output physical_address, output evicted, output evicted_process, output evicted_page
   );
   modport sink (
      input valid, output ready,
      input hit, input page_number, input page_offset, input frame_number,
      input physical_address, input evicted, input evicted_process, input evicted_page
   );
endinterface

@@ hdl/ptf_frame_alloc.sv @@
// Frame allocator: fill counter, round-robin victim pointer and frame owner memory.
module ptf_frame_alloc import ptf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  alloc_ctl_type ctl,
   output alloc_res_type res
);

   owner_type          owner_mem [FRAME_COUNT];
   owner_type          owner_rd_ff;
   logic [LOADED_W-1:0] loaded_ff, loaded_in;
   logic [FRAME_W-1:0]  victim_ff, victim_in;
   logic                full;

   // All frames filled once the counter reaches the frame count
   assign full = (loaded_ff == LOADED_W'(FRAME_COUNT));

   // Chosen frame: next unused one, else the oldest loaded one
   always_comb begin
      res.frame  = full ? victim_ff : loaded_ff[FRAME_W-1:0];
      res.evict  = full;
      res.victim = full ? owner_rd_ff : '0;
   end

   // Counter advances on a fault while frames are free, pointer on a fault once all are full
   always_comb begin
      loaded_in = loaded_ff;
      victim_in = victim_ff;
      if (ctl.commit) begin
         if (full) begin
            victim_in = (victim_ff == FRAME_W'(FRAME_COUNT - 1)) ? '0 : victim_ff + 1'b1;
         end else begin
            loaded_in = loaded_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         victim_ff <= '0;
      end else begin
         loaded_ff <= loaded_in;
         victim_ff <= victim_in;
      end
   end

   // Owner memory: read the victim's owner at accept, write the new owner on a fault
   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         owner_mem[res.frame] <= ctl.owner;
      end
      if (ctl.fetch) begin
         owner_rd_ff <= owner_mem[victim_ff];
      end
   end

endmodule

@@ hdl/paged_translation_fifo_replace.sv @@
// Top level: per-process page table lookup with FIFO frame replacement on faults.
// Each transaction passes through an accept step and a lookup step: at accept the page
// table entry and the owner of the next victim frame are read from their memories, and
// the lookup state then resolves hit or fault, updates the page table, the owner memory and
// the replacement counters, and loads the response register once that register is free or
// being drained. A new request is taken only after the last one has left the lookup state;
// a response still waiting does not block the next request's accept. Page table valid bits
// are flip-flops cleared by reset, so the block needs no clearing pass and is ready right after reset.
module paged_translation_fifo_replace import ptf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ptf_req_if.sink   req_chan,
   ptf_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Page table: valid bits in flops, frame numbers in a memory
   logic [PT_DEPTH-1:0] pt_valid_ff, pt_valid_in;
   logic [FRAME_W-1:0]  pt_frame_mem [PT_DEPTH];
   logic [FRAME_W-1:0]  pt_frame_rd_ff;
   logic                pt_valid_rd_ff;

   // Captured request
   logic [PROC_W-1:0]   proc_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [OFFSET_W-1:0] offset_ff;

   // Response register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                fire;
   logic                fault;
   logic [PT_IDX_W-1:0] req_idx;
   logic [PT_IDX_W-1:0] cur_idx;
   logic [PT_IDX_W-1:0] ev_idx;
   logic [FRAME_W-1:0]  frame;
   alloc_ctl_type       alloc_ctl;
   alloc_res_type       alloc_res;

   // Handshake and indexes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept  = req_chan.valid && req_chan.ready;
   assign fire    = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_idx = {req_chan.process_id, req_chan.virtual_address[VA_W-1 -: PAGE_W]};
   assign cur_idx = {proc_ff, page_ff};
   assign ev_idx  = {alloc_res.victim.proc, alloc_res.victim.page};
   assign fault   = !pt_valid_rd_ff;
   assign frame   = fault ? alloc_res.frame : pt_frame_rd_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         proc_ff   <= req_chan.process_id;
         page_ff   <= req_chan.virtual_address[VA_W-1 -: PAGE_W];
         offset_ff <= req_chan.virtual_address[OFFSET_W-1:0];
      end
   end

   // Page table frame memory: read at accept, write the new mapping on a fault
   always_ff @(posedge clock) begin
      if (fire && fault) begin
         pt_frame_mem[cur_idx] <= frame;
      end
      if (accept) begin
         pt_frame_rd_ff <= pt_frame_mem[req_idx];
      end
   end

   // Valid bits: invalidate the evicted page, then mark the new page present
   always_comb begin
      pt_valid_in = pt_valid_ff;
      if (fire && fault) begin
         if (alloc_res.evict) pt_valid_in[ev_idx] = 1'b0;
         pt_valid_in[cur_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= '0;
      end else begin
         pt_valid_ff <= pt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pt_valid_rd_ff <= pt_valid_ff[req_idx];
      end
   end

   // Frame allocator
   always_comb begin
      alloc_ctl.fetch      = accept;
      alloc_ctl.commit     = fire && fault;
      alloc_ctl.owner.proc = proc_ff;
      alloc_ctl.owner.page = page_ff;
   end

   ptf_frame_alloc u_alloc (
      .clock (clock),
      .reset (reset),
      .ctl   (alloc_ctl),
      .res   (alloc_res)
   );

   // Response assembly
   always_comb begin
      rsp_data_in.hit              = !fault;
      rsp_data_in.page_number      = page_ff;
      rsp_data_in.page_offset      = offset_ff;
      rsp_data_in.frame_number     = frame;
      rsp_data_in.physical_address = {frame, offset_ff};
      rsp_data_in.evicted          = fault && alloc_res.evict;
      rsp_data_in.evicted_process  = fault ? alloc_res.victim.proc : '0;
      rsp_data_in.evicted_page     = fault ? alloc_res.victim.page : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Response port
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.hit              = rsp_data_ff.hit;
   assign rsp_chan.page_number      = rsp_data_ff.page_number;
   assign rsp_chan.page_offset      = rsp_data_ff.page_offset;
   assign rsp_chan.frame_number     = rsp_data_ff.frame_number;
   assign rsp_chan.physical_address = rsp_data_ff.physical_address;
   assign rsp_chan.evicted          = rsp_data_ff.evicted;
   assign rsp_chan.evicted_process  = rsp_data_ff.evicted_process;
   assign rsp_chan.evicted_page     = rsp_data_ff.evicted_page;

endmodule

@@ verif/paged_translation_fifo_replace_tb.sv @@
// Testbench for paged_translation_fifo_replace: page faults, FIFO evictions and hits checked per field.
module paged_translation_fifo_replace_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptf_pkg::*;

   localparam int NUM_PROCS    = 1 << PROC_W;
   localparam int NUM_PAGES    = 1 << PAGE_W;
   localparam int RANDOM_ITEMS = 1525;
   localparam int QUIET_ITEMS  = 200;
   localparam int SET_ITEMS    = 50;
   localparam int DRAIN_CYCLES = 16;

   // Translation predictor plus the queue of responses it expects
   class translation_scoreboard;
      bit                 pt_valid [NUM_PROCS][NUM_PAGES];
      logic [FRAME_W-1:0] pt_frame [NUM_PROCS][NUM_PAGES];
      owner_type          frame_owner [FRAME_COUNT];
      int unsigned        frames_loaded;
      logic [FRAME_W-1:0] victim_frame;
      rsp_type            expected_translations [$];
      int unsigned        error_count;

      function new();
         foreach (pt_valid[p, g]) begin
            pt_valid[p][g] = 1'b0;
            pt_frame[p][g] = '0;
         end
         foreach (frame_owner[f]) frame_owner[f] = '0;
         frames_loaded = 0;
         victim_frame  = '0;
         error_count   = 0;
      endfunction

      // Work out the response to an accepted access and update the tables
      function void note_access(logic [PROC_W-1:0] pid, logic [VA_W-1:0] va);
         rsp_type            want;
         logic [PAGE_W-1:0]  page;
         logic [FRAME_W-1:0] frame;
         owner_type          old_owner;
         page = va[OFFSET_W +: PAGE_W];
         want = '0;
         want.page_number = page;
         want.page_offset = va[OFFSET_W-1:0];
         if (pt_valid[pid][page]) begin
            want.hit = 1'b1;
            frame = pt_frame[pid][page];
         end else begin
            if (frames_loaded < FRAME_COUNT) begin
               // free frames remain: take the next one in order
               frame = frames_loaded[FRAME_W-1:0];
               frames_loaded++;
            end else begin
               // all frames in use: the oldest one goes, its page is unmapped
               frame = victim_frame;
               victim_frame = (victim_frame == FRAME_W'(FRAME_COUNT - 1)) ? '0 : victim_frame + 1'b1;
               old_owner = frame_owner[frame];
               want.evicted         = 1'b1;
               want.evicted_process = old_owner.proc;
               want.evicted_page    = old_owner.page;
               pt_valid[old_owner.proc][old_owner.page] = 1'b0;
            end
            frame_owner[frame].proc = pid;
            frame_owner[frame].page = page;
            pt_valid[pid][page] = 1'b1;
            pt_frame[pid][page] = frame;
         end
         want.frame_number     = frame;
         want.physical_address = {frame, va[OFFSET_W-1:0]};
         expected_translations.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
         end
      endfunction

      // Compare an accepted response with the oldest expected one
      function void check_translation(rsp_type got);
         rsp_type want;
         if (expected_translations.size() == 0) begin
            $error("response transaction with no access pending");
            error_count++;
            return;
         end
         want = expected_translations.pop_front();
         compare_field("hit", want.hit, got.hit);
         compare_field("page_number", want.page_number, got.page_number);
         compare_field("page_offset", want.page_offset, got.page_offset);
         compare_field("frame_number", want.frame_number, got.frame_number);
         compare_field("physical_address", want.physical_address, got.physical_address);
         compare_field("evicted", want.evicted, got.evicted);
         compare_field("evicted_process", want.evicted_process, got.evicted_process);
         compare_field("evicted_page", want.evicted_page, got.evicted_page);
      endfunction

      function int unsigned pending();
         return expected_translations.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   idle_on;

   ptf_req_if req_if ();
   ptf_rsp_if rsp_if ();

   translation_scoreboard sb = new();

   paged_translation_fifo_replace dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #1 clock = ~clock;

   // Watch both channels; responses are checked before the access of the same edge is noted
   always @(posedge clock) begin : channel_monitor
      rsp_type got;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.hit              = rsp_if.hit;
            got.page_number      = rsp_if.page_number;
            got.page_offset      = rsp_if.page_offset;
            got.frame_number     = rsp_if.frame_number;
            got.physical_address = rsp_if.physical_address;
            got.evicted          = rsp_if.evicted;
            got.evicted_process  = rsp_if.evicted_process;
            got.evicted_page     = rsp_if.evicted_page;
            sb.check_translation(got);
         end
         if (req_if.valid && req_if.ready)
            sb.note_access(req_if.process_id, req_if.virtual_address);
      end
   end

   // Response side back-pressure in random bursts
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Present one access, hold it until taken, then maybe pause
   task automatic send_access(logic [PROC_W-1:0] pid, logic [VA_W-1:0] va);
      req_if.valid           <= 1'b1;
      req_if.process_id      <= pid;
      req_if.virtual_address <= va;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Fill every frame, hit on both processes, then walk the FIFO victim
   // pointer all the way round with evictions from both owners
   task automatic directed_accesses();
      send_access(1'b0, 12'h000);
      send_access(1'b0, 12'h0FF);
      send_access(1'b1, 12'hFFF);
      send_access(1'b1, 12'hF00);
      send_access(1'b0, 12'hFFF);
      send_access(1'b1, 12'h000);
      send_access(1'b0, 12'h5A5);
      send_access(1'b1, 12'hA5A);
      send_access(1'b0, 12'h3C3);
      send_access(1'b1, 12'h7FF);
      send_access(1'b0, 12'h0AA);
      send_access(1'b1, 12'h255);
      send_access(1'b0, 12'h001);
      send_access(1'b1, 12'hF80);
      send_access(1'b1, 12'h2FF);
      send_access(1'b0, 12'h800);
      send_access(1'b0, 12'h5FF);
      send_access(1'b1, 12'hC33);
      send_access(1'b0, 12'h5FF);
      send_access(1'b0, 12'h6CC);
      send_access(1'b1, 12'hE11);
      send_access(1'b0, 12'h3C3);
      send_access(1'b1, 12'hF7E);
   endtask

   // Mostly a drifting working set of pages (hits and FIFO churn), some fully random
   task automatic random_accesses(int unsigned count, bit quiet);
      logic [PROC_W-1:0] set_pid [16];
      logic [PAGE_W-1:0] set_page [16];
      int unsigned       set_size;
      int unsigned       pick;
      int unsigned       roll;
      logic [PROC_W-1:0] pid;
      logic [VA_W-1:0]   va;
      set_size = 1;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % SET_ITEMS == 0) begin
            set_size = $urandom_range(3, 14);
            foreach (set_pid[k]) begin
               set_pid[k]  = PROC_W'($urandom_range(0, NUM_PROCS - 1));
               set_page[k] = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
            end
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
         end
         roll = $urandom_range(0, 9);
         pick = $urandom_range(0, set_size - 1);
         if (roll == 9) begin
            set_pid[pick]  = PROC_W'($urandom_range(0, NUM_PROCS - 1));
            set_page[pick] = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
         end
         if (roll == 7 || roll == 8) begin
            pid = PROC_W'($urandom_range(0, NUM_PROCS - 1));
            va  = VA_W'($urandom_range(0, (1 << VA_W) - 1));
         end else begin
            pid = set_pid[pick];
            va  = {set_page[pick], OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1))};
         end
         send_access(pid, va);
      end
      idle_on = 1'b0;
   endtask

   // Main sequence
   initial begin
      idle_on = 1'b0;
      req_if.valid           <= 1'b0;
      req_if.process_id      <= '0;
      req_if.virtual_address <= '0;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;
      directed_accesses();
      random_accesses(RANDOM_ITEMS - QUIET_ITEMS, 1'b0);
      random_accesses(QUIET_ITEMS, 1'b1);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
